/* rtl/radio_rate_word_calculator_core_assert.svh */
// Assertion macros for the rate word calculator.
`ifndef RADIO_RATE_WORD_CALCULATOR_CORE_ASSERT_SVH
`define RADIO_RATE_WORD_CALCULATOR_CORE_ASSERT_SVH

// Condition that must hold on every clock outside reset.
`define RRWC_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define RRWC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/rrwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrwc_pkg
// Shared widths, baud and bandwidth tables, leading-one encoder.
// ---------------------------------------------------------------------------
package rrwc_pkg;

  localparam int XW      = 25;
  localparam int IdxW    = 4;
  localparam int ModW    = 16;
  localparam int BaudW   = 17;
  localparam int ProdW   = 33;
  localparam int CarW    = 34;
  localparam int DivW    = 45;
  localparam int RemW    = 25;
  localparam int PosW    = 6;
  localparam int BwW     = 4;
  localparam int NumLim  = 16;
  localparam int RateShift = 28;
  localparam int DevShift  = 9;

  localparam logic [XW-1:0] CrystalReset = 25'd26000000;

  // bandwidth limits, pre-scaled by 128 (Carson sum compared at half scale)
  localparam logic [CarW-1:0] BwLimit [NumLim] = '{
    34'(812000 * 128), 34'(650000 * 128), 34'(541000 * 128), 34'(464000 * 128),
    34'(406000 * 128), 34'(325000 * 128), 34'(270000 * 128), 34'(232000 * 128),
    34'(203000 * 128), 34'(162000 * 128), 34'(135000 * 128), 34'(116000 * 128),
    34'(102000 * 128), 34'(81000 * 128),  34'(68000 * 128),  34'(58000 * 128)
  };

  function automatic logic [BaudW-1:0] baud_of(input logic [IdxW-1:0] idx);
    logic [BaudW-1:0] b;
    case (idx)
      4'd0:    b = 17'd50;
      4'd1:    b = 17'd110;
      4'd2:    b = 17'd300;
      4'd3:    b = 17'd600;
      4'd4:    b = 17'd1200;
      4'd5:    b = 17'd2400;
      4'd6:    b = 17'd4800;
      4'd7:    b = 17'd9600;
      4'd8:    b = 17'd14400;
      4'd9:    b = 17'd19200;
      4'd10:   b = 17'd28800;
      4'd11:   b = 17'd38400;
      4'd12:   b = 17'd57600;
      4'd13:   b = 17'd76800;
      default: b = 17'd115200;
    endcase
    return b;
  endfunction

  function automatic logic [PosW-1:0] lead_one(input logic [DivW-1:0] v);
    logic [PosW-1:0] p;
    p = '0;
    for (int i = 1; i < DivW; i++) begin
      if (v[i]) p = PosW'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/rrwc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrwc_front
// Baud lookup, deviation and Carson products, bandwidth search (3 stages).
// ---------------------------------------------------------------------------
module rrwc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_v,
  input  wire logic [rrwc_pkg::IdxW-1:0]   rate_index,
  input  wire logic [rrwc_pkg::ModW-1:0]   modulation_index,
  input  wire logic [rrwc_pkg::XW-1:0]     crystal,
  output logic                             out_v,
  output logic [rrwc_pkg::XW-1:0]          x_out,
  output logic [rrwc_pkg::DivW-1:0]        dvd_rate,
  output logic [rrwc_pkg::DivW-1:0]        dvd_dev,
  output logic [rrwc_pkg::BwW-1:0]         bw_code
);
  import rrwc_pkg::*;

  logic             v1, v2, v3;
  logic [BaudW-1:0] b1, b3;
  logic [ModW-1:0]  m1;
  logic [XW-1:0]    x1, x2, x3;
  logic [ProdW-1:0] d2, d3;
  logic [CarW-1:0]  c2;
  logic [BaudW-1:0] b2;
  logic [BwW-1:0]   bw_next;

  always_comb begin
    bw_next = BwW'(NumLim - 1);
    for (int k = NumLim - 1; k >= 0; k--) begin
      if (c2 > BwLimit[k]) bw_next = BwW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1 <= baud_of(rate_index);
      m1 <= modulation_index;
      x1 <= (crystal == '0) ? XW'(1) : crystal;
      x2 <= x1;
      b2 <= b1;
      d2 <= ProdW'(b1 * m1);
      c2 <= CarW'(b1 * ({1'b0, m1} + 17'd256));
      x3 <= x2;
      b3 <= b2;
      d3 <= d2;
      bw_code <= bw_next;
    end
  end

  assign out_v    = v3;
  assign x_out    = x3;
  assign dvd_rate = {b3, {RateShift{1'b0}}};
  assign dvd_dev  = {{(DivW - ProdW - DevShift){1'b0}}, d3, {DevShift{1'b0}}};

endmodule
`default_nettype wire

/* rtl/rrwc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrwc_div
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
// ---------------------------------------------------------------------------
module rrwc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_v,
  input  wire logic [rrwc_pkg::XW-1:0]   x_in,
  input  wire logic [rrwc_pkg::DivW-1:0] dvd_rate,
  input  wire logic [rrwc_pkg::DivW-1:0] dvd_dev,
  input  wire logic [rrwc_pkg::BwW-1:0]  bw_in,
  output logic                           out_v,
  output logic [rrwc_pkg::DivW-1:0]      quo_rate,
  output logic [rrwc_pkg::DivW-1:0]      quo_dev,
  output logic [rrwc_pkg::BwW-1:0]       bw_out
);
  import rrwc_pkg::*;

  logic            v   [DivW+1];
  logic [XW-1:0]   x   [DivW+1];
  logic [RemW-1:0] rr  [DivW+1];
  logic [DivW-1:0] nr  [DivW+1];
  logic [RemW-1:0] rd  [DivW+1];
  logic [DivW-1:0] nd  [DivW+1];
  logic [BwW-1:0]  sb  [DivW+1];

  assign v[0]  = in_v;
  assign x[0]  = x_in;
  assign rr[0] = '0;
  assign nr[0] = dvd_rate;
  assign rd[0] = '0;
  assign nd[0] = dvd_dev;
  assign sb[0] = bw_in;

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [RemW:0] tr, td, sr, sd;
    logic          ger, ged;

    assign tr  = {rr[s], nr[s][DivW-1]};
    assign td  = {rd[s], nd[s][DivW-1]};
    assign sr  = tr - {1'b0, x[s]};
    assign sd  = td - {1'b0, x[s]};
    assign ger = tr >= {1'b0, x[s]};
    assign ged = td >= {1'b0, x[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x[s+1]  <= x[s];
        rr[s+1] <= ger ? sr[RemW-1:0] : tr[RemW-1:0];
        rd[s+1] <= ged ? sd[RemW-1:0] : td[RemW-1:0];
        nr[s+1] <= {nr[s][DivW-2:0], ger};
        nd[s+1] <= {nd[s][DivW-2:0], ged};
        sb[s+1] <= sb[s];
      end
    end
  end

  assign out_v    = v[DivW];
  assign quo_rate = nr[DivW];
  assign quo_dev  = nd[DivW];
  assign bw_out   = sb[DivW];

endmodule
`default_nettype wire

/* rtl/rrwc_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rrwc_norm
// Leading-one encode, then exponent/mantissa extraction into output regs.
// ---------------------------------------------------------------------------
module rrwc_norm (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      in_v,
  input  wire logic [rrwc_pkg::DivW-1:0] quo_rate,
  input  wire logic [rrwc_pkg::DivW-1:0] quo_dev,
  input  wire logic [rrwc_pkg::BwW-1:0]  bw_in,
  output logic                           out_v,
  output logic [3:0]                     rate_exponent,
  output logic [7:0]                     rate_mantissa,
  output logic [2:0]                     deviation_exponent,
  output logic [2:0]                     deviation_mantissa,
  output logic [1:0]                     bandwidth_exponent,
  output logic [1:0]                     bandwidth_mantissa,
  output logic                           error_code
);
  import rrwc_pkg::*;
  `include "radio_rate_word_calculator_core_assert.svh"

  logic            v1, v2;
  logic [DivW-1:0] qr1, qd1, shr, shd;
  logic [BwW-1:0]  bw1;
  logic [PosW-1:0] lr1, ld1, er, ed;
  logic            err;

  assign er  = (lr1 >= PosW'(9)) ? (lr1 - PosW'(8)) : '0;
  assign ed  = ld1 - PosW'(3);
  assign err = (qd1[DivW-1:3] == '0);
  assign shr = qr1 >> er;
  assign shd = qd1 >> ed;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_v;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qr1 <= quo_rate;
      qd1 <= quo_dev;
      bw1 <= bw_in;
      lr1 <= lead_one(quo_rate);
      ld1 <= lead_one(quo_dev);
      rate_exponent      <= er[3:0];
      rate_mantissa      <= shr[7:0];
      deviation_exponent <= err ? 3'd0 : ed[2:0];
      deviation_mantissa <= err ? 3'd0 : shd[2:0];
      bandwidth_exponent <= bw1[3:2];
      bandwidth_mantissa <= bw1[1:0];
      error_code         <= err;
    end
  end

  assign out_v = v2;

  `RRWC_ASSERT(a_rate_lead, clk, rst, !v1 || qr1[DivW-1:9] == '0 || lr1 >= PosW'(9), "rate lead")
  `RRWC_ASSERT_IMP(a_dev_lead, clk, rst, v1 && !err, ld1 >= PosW'(3), "deviation lead")
  `RRWC_ASSERT_IMP(a_err_zero, clk, rst, v2 && error_code,
                   deviation_exponent == 3'd0 && deviation_mantissa == 3'd0, "err fields")

endmodule
`default_nettype wire

/* rtl/radio_rate_word_calculator_core.sv */
// Pipeline from request accept to result valid: front, divider, then normalize stages.
// Throughput: one request per cycle unless stalled; set by the one-bit-per-stage divider pipeline.
// Whole pipeline holds while the output register is full and not taken.
// Reset: synchronous, active high; clears valid bits, crystal register to 26000000.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// radio_rate_word_calculator_core
// Data rate, deviation and channel bandwidth register words.
// ---------------------------------------------------------------------------
module radio_rate_word_calculator_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [rrwc_pkg::XW-1:0]     cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rrwc_pkg::IdxW-1:0]   rate_index,
  input  wire logic [rrwc_pkg::ModW-1:0]   modulation_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [3:0]                       rate_exponent,
  output logic [7:0]                       rate_mantissa,
  output logic [2:0]                       deviation_exponent,
  output logic [2:0]                       deviation_mantissa,
  output logic [1:0]                       bandwidth_exponent,
  output logic [1:0]                       bandwidth_mantissa,
  output logic                             error_code
);
  import rrwc_pkg::*;

  logic            adv;
  logic [XW-1:0]   crystal_hz;
  logic            f_v, d_v;
  logic [XW-1:0]   f_x;
  logic [DivW-1:0] f_dr, f_dd, q_r, q_d;
  logic [BwW-1:0]  f_bw, d_bw;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz <= CrystalReset;
    end else if (cfg_we) begin
      crystal_hz <= cfg_wdata;
    end
  end

  rrwc_front u_front (
    .clk, .rst, .adv,
    .in_v             (in_valid),
    .rate_index,
    .modulation_index,
    .crystal          (crystal_hz),
    .out_v            (f_v),
    .x_out            (f_x),
    .dvd_rate         (f_dr),
    .dvd_dev          (f_dd),
    .bw_code          (f_bw)
  );

  rrwc_div u_div (
    .clk, .rst, .adv,
    .in_v     (f_v),
    .x_in     (f_x),
    .dvd_rate (f_dr),
    .dvd_dev  (f_dd),
    .bw_in    (f_bw),
    .out_v    (d_v),
    .quo_rate (q_r),
    .quo_dev  (q_d),
    .bw_out   (d_bw)
  );

  rrwc_norm u_norm (
    .clk, .rst, .adv,
    .in_v     (d_v),
    .quo_rate (q_r),
    .quo_dev  (q_d),
    .bw_in    (d_bw),
    .out_v    (out_valid),
    .rate_exponent,
    .rate_mantissa,
    .deviation_exponent,
    .deviation_mantissa,
    .bandwidth_exponent,
    .bandwidth_mantissa,
    .error_code
  );

endmodule
`default_nettype wire
